>>> src/lcdt_pkg.sv
// ----------------------------------------------------------------------------
// lcdt_pkg
// Shared types and timing constants for the scanline mode timer.
// ----------------------------------------------------------------------------
`default_nettype none

package lcdt_pkg;

  // Frame geometry.
  localparam int DOTS_PER_LINE = 456;
  localparam int VISIBLE_LINES = 144;
  localparam int TOTAL_LINES   = 154;
  localparam int VISIBLE_WIDTH = 160;

  // Field widths.
  localparam int DotW  = 9;
  localparam int LineW = 8;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 8;

  // Fixed dots within a line.
  localparam logic [DotW-1:0]  LAST_DOT       = DotW'(DOTS_PER_LINE - 1);
  localparam logic [DotW-1:0]  SCAN_END_DOT   = DotW'(79);
  localparam logic [DotW-1:0]  DRAW_START_DOT = DotW'(80);
  localparam logic [DotW-1:0]  DRAW_END_DOT   = DotW'(91 + VISIBLE_WIDTH);
  localparam logic [DotW:0]    LINE_WRAP_DOT  = (DotW+1)'(DOTS_PER_LINE);
  localparam logic [DotW-1:0]  VIS_WIDTH_DOTS = DotW'(VISIBLE_WIDTH);

  // Fixed lines within a frame.
  localparam logic [LineW-1:0] LAST_VIS_LINE  = LineW'(VISIBLE_LINES - 1);
  localparam logic [LineW-1:0] LAST_LINE      = LineW'(TOTAL_LINES - 1);
  localparam logic [LineW:0]   FRAME_WRAP     = (LineW+1)'(TOTAL_LINES);
  localparam logic [7:0]       WINDOW_X_LIMIT = 8'd166;

  // Display modes.
  typedef enum logic [1:0] {
    MODE_HBLANK = 2'd0,
    MODE_VBLANK = 2'd1,
    MODE_OAM    = 2'd2,
    MODE_DRAW   = 2'd3
  } mode_t;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_LCD_ENABLE    = 3'd0,
    CFG_WINDOW_ENABLE = 3'd1,
    CFG_IRQ_SELECT    = 3'd2,
    CFG_COMPARE_LINE  = 3'd3,
    CFG_WINDOW_TOP    = 3'd4,
    CFG_WINDOW_LEFT   = 3'd5
  } cfg_idx_t;

  // Bits of the status interrupt select register.
  localparam int IRQ_HBLANK_BIT  = 0;
  localparam int IRQ_VBLANK_BIT  = 1;
  localparam int IRQ_OAM_BIT     = 2;
  localparam int IRQ_COMPARE_BIT = 3;

endpackage

`default_nettype wire

>>> src/lcd_scanline_mode_timer.sv
// ----------------------------------------------------------------------------
// lcd_scanline_mode_timer
// Dot and line timing of a scanline display controller: mode sequencing,
// line compare, window line counter and status/vblank interrupt requests.
// ----------------------------------------------------------------------------
// Usage:
//   Each item on the in_ channel is one dot tick; in_advance = 1 moves the
//   timing on by one dot, 0 only reports the current state. Every accepted
//   item yields exactly one result on the out_ channel, holding the state
//   after the tick plus the interrupt and pixel flags of that tick.
//   The tick is captured in an input register; once the result register is
//   free, it is applied to the timing counters and loads the result register,
//   which raises out_valid. One item is taken every cycle while the result
//   register is free (out_stall low or result register empty).
//   When out_stall is high and the result register is full, the input
//   register keeps its item and in_stall rises, so no item is lost.
//   The cfg_ channel is always ready; writes to unknown indexes are dropped.
//   The user must write only while no item is in flight; it is not enforced.
//   Synchronous reset (rst_n low) empties both registers, sets the timing to
//   line 0, dot 0 in OAM scan, and loads the registers' reset values
//   (display enabled, everything else zero).
// ----------------------------------------------------------------------------
`default_nettype none

module lcd_scanline_mode_timer (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // Tick input
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_advance,
  // Result output
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [1:0]                         out_display_mode,
  output logic [lcdt_pkg::LineW-1:0]         out_current_line,
  output logic [lcdt_pkg::DotW-1:0]          out_current_dot,
  output logic                               out_line_match,
  output logic                               out_status_irq,
  output logic                               out_vblank_irq,
  output logic [7:0]                         out_window_line,
  output logic                               out_pixel_valid,
  output logic [7:0]                         out_pixel_x,
  // Configuration writes
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [lcdt_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [lcdt_pkg::CfgDataW-1:0] cfg_data
);

  import lcdt_pkg::*;

  // Configuration registers.
  logic       lcd_en_r;
  logic       win_en_r;
  logic [3:0] irq_sel_r;
  logic [7:0] cmp_line_r;
  logic [7:0] win_top_r;
  logic [7:0] win_left_r;

  // Timing state.
  logic [DotW-1:0]  dot_r,   dot_nxt;
  logic [LineW-1:0] line_r,  line_nxt;
  mode_t            mode_r,  mode_nxt;
  logic [7:0]       wline_r, wline_nxt;
  logic             latch_r, latch_nxt;
  logic             match_r, match_nxt;

  // Pipeline registers.
  logic             s1_valid_r;
  logic             s1_adv_r;
  logic             out_valid_r;
  logic             stat_irq_nxt, vb_irq_nxt, pix_valid_nxt;
  logic [7:0]       pix_x_nxt;
  logic             out_take, s1_move, in_take;

  // Interrupt enable bit that belongs to a mode; drawing has none.
  function automatic logic mode_irq_en(input mode_t m, input logic [3:0] sel);
    logic en;
    en = 1'b0;
    unique case (m)
      MODE_HBLANK: en = sel[IRQ_HBLANK_BIT];
      MODE_VBLANK: en = sel[IRQ_VBLANK_BIT];
      MODE_OAM:    en = sel[IRQ_OAM_BIT];
      MODE_DRAW:   en = 1'b0;
      default:     en = 1'b0;
    endcase
    return en;
  endfunction

  // Handshake: the result register frees up when empty or taken.
  assign out_take  = !out_valid_r || !out_stall;
  assign s1_move   = s1_valid_r && out_take;
  assign in_stall  = s1_valid_r && !out_take;
  assign in_take   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign cfg_ready = 1'b1;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lcd_en_r   <= 1'b1;
      win_en_r   <= 1'b0;
      irq_sel_r  <= '0;
      cmp_line_r <= '0;
      win_top_r  <= '0;
      win_left_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_LCD_ENABLE:    lcd_en_r   <= cfg_data[0];
        CFG_WINDOW_ENABLE: win_en_r   <= cfg_data[0];
        CFG_IRQ_SELECT:    irq_sel_r  <= cfg_data[3:0];
        CFG_COMPARE_LINE:  cmp_line_r <= cfg_data;
        CFG_WINDOW_TOP:    win_top_r  <= cfg_data;
        CFG_WINDOW_LEFT:   win_left_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // One dot tick applied to the timing state.
  always_comb begin
    logic [DotW-1:0]  dot_inc;
    logic [DotW-1:0]  draw_off;
    logic [LineW-1:0] line_inc;
    logic             latch_mid;

    dot_nxt       = dot_r;
    line_nxt      = line_r;
    mode_nxt      = mode_r;
    wline_nxt     = wline_r;
    latch_nxt     = latch_r;
    match_nxt     = match_r;
    stat_irq_nxt  = 1'b0;
    vb_irq_nxt    = 1'b0;
    pix_valid_nxt = 1'b0;
    pix_x_nxt     = '0;
    dot_inc       = dot_r + 1'b1;
    draw_off      = dot_r - DRAW_START_DOT;
    line_inc      = line_r + 1'b1;
    latch_mid     = latch_r;

    if (s1_adv_r && lcd_en_r) begin
      // Mode interrupt on entry to this tick.
      if (!latch_r && mode_irq_en(mode_r, irq_sel_r)) begin
        stat_irq_nxt = 1'b1;
      end

      // Mode changes at fixed dots.
      unique case (mode_r)
        MODE_HBLANK: begin
          if (dot_r == LAST_DOT) begin
            if (line_r == LAST_VIS_LINE) begin
              mode_nxt   = MODE_VBLANK;
              vb_irq_nxt = 1'b1;
            end else begin
              mode_nxt = MODE_OAM;
            end
          end
        end
        MODE_VBLANK: begin
          if (dot_r == LAST_DOT && line_r == LAST_LINE) begin
            mode_nxt = MODE_OAM;
          end
        end
        MODE_OAM: begin
          if (dot_r == SCAN_END_DOT) begin
            mode_nxt = MODE_DRAW;
          end
        end
        MODE_DRAW: begin
          if (dot_r >= DRAW_START_DOT && draw_off < VIS_WIDTH_DOTS) begin
            pix_valid_nxt = 1'b1;
            pix_x_nxt     = draw_off[7:0];
          end else if (dot_r == DRAW_END_DOT) begin
            mode_nxt = MODE_HBLANK;
          end
        end
        default: ;
      endcase

      // Dot, line and window line counters.
      dot_nxt = dot_inc;
      if ({1'b0, dot_inc} == LINE_WRAP_DOT) begin
        dot_nxt  = '0;
        line_nxt = line_inc;
        if (win_en_r && win_top_r <= line_r && win_left_r < WINDOW_X_LIMIT) begin
          wline_nxt = wline_r + 1'b1;
        end
        if ({1'b0, line_inc} == FRAME_WRAP) begin
          line_nxt  = '0;
          wline_nxt = '0;
          latch_mid = 1'b0;
        end
      end

      // Line compare and the status line latch.
      match_nxt = (line_nxt == cmp_line_r);
      if (!latch_mid && match_nxt && irq_sel_r[IRQ_COMPARE_BIT]) begin
        stat_irq_nxt = 1'b1;
      end
      latch_nxt = match_nxt || mode_irq_en(mode_nxt, irq_sel_r);
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_move) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_adv_r <= in_advance;
    end
  end

  // Timing state advances as an item moves into the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_r   <= '0;
      line_r  <= '0;
      mode_r  <= MODE_OAM;
      wline_r <= '0;
      latch_r <= 1'b0;
      match_r <= 1'b0;
    end else if (s1_move) begin
      dot_r   <= dot_nxt;
      line_r  <= line_nxt;
      mode_r  <= mode_nxt;
      wline_r <= wline_nxt;
      latch_r <= latch_nxt;
      match_r <= match_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_take) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_display_mode <= mode_nxt;
      out_current_line <= line_nxt;
      out_current_dot  <= dot_nxt;
      out_line_match   <= match_nxt;
      out_status_irq   <= stat_irq_nxt;
      out_vblank_irq   <= vb_irq_nxt;
      out_window_line  <= wline_nxt;
      out_pixel_valid  <= pix_valid_nxt;
      out_pixel_x      <= pix_x_nxt;
    end
  end

  // Checks on the timing logic.
  a_pixel_in_draw: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_pixel_valid |-> out_display_mode == MODE_DRAW)
    else $error("pixel reported outside drawing mode");

  a_vblank_entry: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_vblank_irq |->
      out_display_mode == MODE_VBLANK && out_current_dot == '0)
    else $error("vblank interrupt without entry to vblank at line start");

  a_dot_range: assert property (@(posedge clk) disable iff (!rst_n)
    dot_r <= LAST_DOT && line_r <= LAST_LINE)
    else $error("dot or line counter out of range");

  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_move |=> $stable(dot_r) && $stable(line_r) && $stable(mode_r))
    else $error("timing state changed without a tick");

endmodule

`default_nettype wire
